[rtl/dse_pkg.sv]
// Package: shared codes, widths and reset values for the subsequence enumerator.
`timescale 1ns / 1ps
`default_nettype none
package dse_pkg;

    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int SUBLEN_W = 9;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SUBLEN_W-1:0] sublen_t;

    localparam kind_t K_CLEAR  = 2'd0;
    localparam kind_t K_APPEND = 2'd1;
    localparam kind_t K_BUILD  = 2'd2;
    localparam kind_t K_NEXT   = 2'd3;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_FULL        = 3'd1;
    localparam status_t ST_OUTSIDE     = 3'd2;
    localparam status_t ST_EXHAUSTED   = 3'd3;
    localparam status_t ST_NOT_STARTED = 3'd4;

    localparam char_t BASE_CHAR_RESET = 8'd97;

endpackage
`default_nettype wire

[rtl/dse_in_if.sv]
// Interface: input channel carrying command kind and character code.
`timescale 1ns / 1ps
`default_nettype none
interface dse_in_if;
    logic             valid;
    logic             ready;
    dse_pkg::kind_t   kind;
    dse_pkg::char_t   char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface
`default_nettype wire

[rtl/dse_out_if.sv]
// Interface: result channel carrying status, subsequence length and last character.
`timescale 1ns / 1ps
`default_nettype none
interface dse_out_if;
    logic              valid;
    logic              ready;
    dse_pkg::status_t  status;
    dse_pkg::sublen_t  sub_length;
    dse_pkg::char_t    last_char;

    modport source (output valid, output status, output sub_length, output last_char,
                    input ready);
    modport sink   (input valid, input status, input sub_length, input last_char,
                    output ready);
endinterface
`default_nettype wire

[rtl/distinct_subsequence_enumerator.sv]
// Top level: distinct subsequence enumerator built on a subsequence automaton.
// Clear and append register their result in the cycle after the transfer; build walks
//   the table downward one entry per walk step, sentinel rows first (n = string length).
// Next scans letters and pops levels until a hit or exhaustion; one item is in work at a time.
// Reset (rst_n low, asynchronous) empties the string, stops the enumeration and sets
//   base_char to 97; the memories hold no reset and are written before any read.
`timescale 1ns / 1ps
`default_nettype none
module distinct_subsequence_enumerator #(
    parameter int MAX_LEN  = 256,
    parameter int ALPHABET = 26
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire dse_pkg::char_t cfg_wdata,
    dse_in_if.sink             in_ch,
    dse_out_if.source          out_ch
);

    // Widths derived from the parameters.
    localparam int LW        = $clog2(ALPHABET);              // letter index
    localparam int LCW       = $clog2(ALPHABET + 1);          // scan counter, may reach ALPHABET
    localparam int PW        = $clog2(MAX_LEN + 2);           // table entry, up to MAX_LEN+1
    localparam int DW        = $clog2(MAX_LEN + 1);           // depth and string length
    localparam int XW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TBL_DEPTH = (MAX_LEN + 2) * ALPHABET;
    localparam int TAW       = $clog2(TBL_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_BFILL  = 9'b000000010,   // sentinel rows n and n+1
        S_BRD    = 9'b000000100,   // read row+1 and the string letter
        S_BWR    = 9'b000001000,   // write row entry
        S_ASTART = 9'b000010000,   // form the row base of the current position
        S_ARD    = 9'b000100000,   // read one table entry
        S_ACHK   = 9'b001000000,   // test it, push on a hit
        S_AFAIL  = 9'b010000000,   // pop one level or report exhausted
        S_APOP   = 9'b100000000    // reload top of stack
    } state_t;

    state_t            state_reg, state_next;
    dse_pkg::char_t    base_reg;
    logic [DW-1:0]     text_len_reg, text_len_next;
    logic              started_reg, started_next;
    logic [PW-1:0]     sentinel_reg, sentinel_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [LW-1:0]     top_let_reg, top_let_next;
    logic [PW-1:0]     pos_top_reg, pos_top_next;
    logic [LCW-1:0]    from_reg, from_next;
    logic [TAW-1:0]    rowbase_reg, rowbase_next;
    logic [PW-1:0]     brow_reg, brow_next;
    logic [LW-1:0]     blet_reg, blet_next;
    logic [TAW-1:0]    addr_reg, addr_next;

    logic              out_valid_reg, out_valid_next;
    dse_pkg::status_t  status_reg, status_next;
    dse_pkg::sublen_t  len_reg, len_next;
    dse_pkg::char_t    char_reg, char_next;

    // Memories: one write and one registered read port each.
    logic [LW-1:0]  text_mem [MAX_LEN];
    logic           text_we;
    logic [XW-1:0]  text_wa, text_ra;
    logic [LW-1:0]  text_wd, text_rd_reg;

    logic [PW-1:0]  tbl_mem [TBL_DEPTH];
    logic           tbl_we;
    logic [TAW-1:0] tbl_wa, tbl_ra;
    logic [PW-1:0]  tbl_wd, tbl_rd_reg;

    logic [PW-1:0]  pos_mem [MAX_LEN + 1];
    logic           pos_we;
    logic [DW-1:0]  pos_wa, pos_ra;
    logic [PW-1:0]  pos_wd, pos_rd_reg;

    logic [LW-1:0]  let_mem [MAX_LEN];
    logic           let_we;
    logic [XW-1:0]  let_wa, let_ra;
    logic [LW-1:0]  let_wd, let_rd_reg;

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_wa] <= text_wd;
        end
        text_rd_reg <= text_mem[text_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_rd_reg <= tbl_mem[tbl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        pos_rd_reg <= pos_mem[pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (let_we)
        begin
            let_mem[let_wa] <= let_wd;
        end
        let_rd_reg <= let_mem[let_ra];
    end

    // Take a new item only when idle and the result slot is free or draining.
    assign in_ch.ready      = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.sub_length = len_reg;
    assign out_ch.last_char  = char_reg;

    logic              in_fire;
    logic [8:0]        diff;
    logic              outside;
    logic [PW-1:0]     n_pw;
    logic [PW-1:0]     nrow;
    logic              out_load;
    dse_pkg::status_t  st;
    logic              build_step;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign diff    = {1'b0, in_ch.char_code} - {1'b0, base_reg};
    assign outside = diff[8] || (diff[7:0] >= 8'(ALPHABET));
    assign n_pw    = PW'(text_len_reg);
    assign nrow    = (blet_reg == '0) ? (brow_reg - 1'b1) : brow_reg;

    always_comb
    begin
        state_next    = state_reg;
        text_len_next = text_len_reg;
        started_next  = started_reg;
        sentinel_next = sentinel_reg;
        depth_next    = depth_reg;
        top_let_next  = top_let_reg;
        pos_top_next  = pos_top_reg;
        from_next     = from_reg;
        rowbase_next  = rowbase_reg;
        brow_next     = brow_reg;
        blet_next     = blet_reg;
        addr_next     = addr_reg;
        out_load      = 1'b0;
        st            = dse_pkg::ST_OK;
        build_step    = 1'b0;

        text_we = 1'b0;
        text_wa = XW'(text_len_reg);
        text_wd = LW'(diff[7:0]);
        text_ra = XW'(brow_reg);
        tbl_we  = 1'b0;
        tbl_wa  = addr_reg;
        tbl_wd  = n_pw + 1'b1;
        tbl_ra  = TAW'(addr_reg + TAW'(ALPHABET));
        pos_we  = 1'b0;
        pos_wa  = '0;
        pos_wd  = '0;
        pos_ra  = depth_reg - 1'b1;
        let_we  = 1'b0;
        let_wa  = XW'(depth_reg);
        let_wd  = LW'(from_reg);
        let_ra  = XW'(depth_reg - DW'(2));

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.kind)
                        dse_pkg::K_CLEAR:
                        begin
                            text_len_next = '0;
                            depth_next    = '0;
                            started_next  = 1'b0;
                            out_load      = 1'b1;
                        end
                        dse_pkg::K_APPEND:
                        begin
                            out_load = 1'b1;
                            if (outside)
                            begin
                                st = dse_pkg::ST_OUTSIDE;
                            end
                            else if (32'(text_len_reg) >= MAX_LEN)
                            begin
                                st = dse_pkg::ST_FULL;
                            end
                            else
                            begin
                                text_we       = 1'b1;
                                text_len_next = text_len_reg + 1'b1;
                            end
                        end
                        dse_pkg::K_BUILD:
                        begin
                            // Walk the table downward from the last entry of row n+1.
                            addr_next     = TAW'((32'(text_len_reg) + 32'd2) * ALPHABET - 1);
                            brow_next     = n_pw + 1'b1;
                            blet_next     = LW'(ALPHABET - 1);
                            sentinel_next = n_pw + 1'b1;
                            state_next    = S_BFILL;
                        end
                        default:
                        begin
                            if (!started_reg)
                            begin
                                st       = dse_pkg::ST_NOT_STARTED;
                                out_load = 1'b1;
                            end
                            else
                            begin
                                from_next  = '0;
                                state_next = S_ASTART;
                            end
                        end
                    endcase
                end
            end
            S_BFILL:
            begin
                tbl_we     = 1'b1;
                build_step = 1'b1;
            end
            S_BRD:
            begin
                state_next = S_BWR;
            end
            S_BWR:
            begin
                tbl_we     = 1'b1;
                tbl_wd     = (text_rd_reg == blet_reg) ? (brow_reg + 1'b1) : tbl_rd_reg;
                build_step = 1'b1;
            end
            S_ASTART:
            begin
                rowbase_next = TAW'(32'(pos_top_reg) * ALPHABET);
                state_next   = S_ARD;
            end
            S_ARD:
            begin
                tbl_ra = TAW'(rowbase_reg + TAW'(from_reg));
                if ((32'(from_reg) == ALPHABET) || (32'(depth_reg) == MAX_LEN))
                begin
                    state_next = S_AFAIL;
                end
                else
                begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                if ((tbl_rd_reg != sentinel_reg) && (32'(tbl_rd_reg) <= MAX_LEN))
                begin
                    // Push the letter and the position just after it.
                    let_we       = 1'b1;
                    pos_we       = 1'b1;
                    pos_wa       = depth_reg + 1'b1;
                    pos_wd       = tbl_rd_reg;
                    depth_next   = depth_reg + 1'b1;
                    pos_top_next = tbl_rd_reg;
                    top_let_next = LW'(from_reg);
                    out_load     = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    from_next  = from_reg + 1'b1;
                    state_next = S_ARD;
                end
            end
            S_AFAIL:
            begin
                if (depth_reg == '0)
                begin
                    st         = dse_pkg::ST_EXHAUSTED;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Resume the parent level after the letter just popped.
                    from_next  = LCW'(top_let_reg) + 1'b1;
                    depth_next = depth_reg - 1'b1;
                    state_next = S_APOP;
                end
            end
            S_APOP:
            begin
                pos_top_next = pos_rd_reg;
                top_let_next = let_rd_reg;
                state_next   = S_ASTART;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (build_step)
        begin
            if (addr_reg == '0)
            begin
                // Table complete: start from the empty subsequence.
                started_next = 1'b1;
                depth_next   = '0;
                pos_top_next = '0;
                pos_we       = 1'b1;
                out_load     = 1'b1;
                state_next   = S_IDLE;
            end
            else
            begin
                addr_next  = addr_reg - 1'b1;
                brow_next  = nrow;
                blet_next  = (blet_reg == '0) ? LW'(ALPHABET - 1) : (blet_reg - 1'b1);
                state_next = (nrow >= n_pw) ? S_BFILL : S_BRD;
            end
        end

        out_valid_next = out_valid_reg && !out_ch.ready;
        status_next    = status_reg;
        len_next       = len_reg;
        char_next      = char_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = st;
            len_next       = dse_pkg::sublen_t'(depth_next);
            char_next      = (depth_next != '0) ? (base_reg + 8'(top_let_next)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= dse_pkg::BASE_CHAR_RESET;
            text_len_reg  <= '0;
            started_reg   <= 1'b0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            text_len_reg  <= text_len_next;
            started_reg   <= started_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // Payload and working registers: no reset needed.
    always_ff @(posedge clk)
    begin
        sentinel_reg <= sentinel_next;
        top_let_reg  <= top_let_next;
        pos_top_reg  <= pos_top_next;
        from_reg     <= from_next;
        rowbase_reg  <= rowbase_next;
        brow_reg     <= brow_next;
        blet_reg     <= blet_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        len_reg      <= len_next;
        char_reg     <= char_next;
    end

endmodule
`default_nettype wire
